>>> hw/rtl/fmeg_pkg.sv
// Shared types, codes, increment table and rate helper functions for the
// FM operator envelope generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fmeg_pkg;

  typedef enum logic [1:0] {
    PH_ATTACK  = 2'd0,
    PH_DECAY   = 2'd1,
    PH_SUSTAIN = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_PHASE = 2'd1,
    OP_RESTART   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KS_DIV8  = 2'd0,
    KS_DIV2  = 2'd1,
    KS_REMAP = 2'd2,
    KS_NONE  = 2'd3
  } ks_mode_t;

  typedef enum logic [2:0] {
    REG_ATTACK_RATE   = 3'd0,
    REG_DECAY_RATE    = 3'd1,
    REG_SUSTAIN_RATE  = 3'd2,
    REG_RELEASE_RATE  = 3'd3,
    REG_SUSTAIN_LEVEL = 3'd4,
    REG_KS_MODE       = 3'd5,
    REG_KEY_CODE      = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } ctrl_state_t;

  localparam int unsigned ATTEN_W = 10;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 5;

  localparam logic [ATTEN_W-1:0] ATT_MAX = 10'd511;
  localparam logic [ATTEN_W-1:0] ATT_SAT = 10'd1023;

  // Increment rows: 0..3 by (index & 3) below index 52, 4..15 for 52..63.
  localparam logic [2:0] INC_ROWS [16][8] = '{
    '{3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1},
    '{3'd0, 3'd1, 3'd0, 3'd1, 3'd1, 3'd1, 3'd0, 3'd1},
    '{3'd0, 3'd1, 3'd1, 3'd1, 3'd0, 3'd1, 3'd1, 3'd1},
    '{3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
    '{3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
    '{3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2},
    '{3'd1, 3'd2, 3'd1, 3'd2, 3'd1, 3'd2, 3'd1, 3'd2},
    '{3'd1, 3'd2, 3'd2, 3'd2, 3'd1, 3'd2, 3'd2, 3'd2},
    '{3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2},
    '{3'd2, 3'd2, 3'd2, 3'd4, 3'd2, 3'd2, 3'd2, 3'd4},
    '{3'd2, 3'd4, 3'd2, 3'd4, 3'd2, 3'd4, 3'd2, 3'd4},
    '{3'd2, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4, 3'd4, 3'd4},
    '{3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4},
    '{3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4},
    '{3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4},
    '{3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4}
  };

  typedef struct packed {
    logic [3:0] attack_rate;
    logic [3:0] decay_rate;
    logic [3:0] sustain_rate;
    logic [3:0] release_rate;
    logic [3:0] sustain_level;
    ks_mode_t   ks_mode;
    logic [4:0] key_code;
  } cfg_t;

  typedef struct packed {
    logic start;     // apply the accepted beat
    logic ovf_step;  // run one period overflow
    logic load_out;  // capture state into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic ovf_pending;
  } dp_sts_t;

  // Four times the rate plus the key-scaling term, capped at 63.
  function automatic logic [5:0] rate_index(input logic [3:0] rate,
                                            input ks_mode_t mode,
                                            input logic [4:0] kc);
    logic [3:0] ks;
    logic [6:0] sum;
    case (mode)
      KS_DIV8:  ks = {2'b00, kc[4:3]};
      KS_DIV2:  ks = kc[4:1];
      KS_REMAP: ks = {kc[4:2], kc[0]};
      default:  ks = 4'd0;
    endcase
    sum = {1'b0, rate, 2'b00} + {3'b000, ks};
    return (sum > 7'd63) ? 6'd63 : sum[5:0];
  endfunction

  function automatic logic [2:0] inc_lookup(input logic [5:0] idx,
                                            input logic [2:0] step);
    logic [3:0] row;
    row = (idx < 6'd52) ? {2'b00, idx[1:0]} : idx[3:0];
    return INC_ROWS[row][step];
  endfunction

  function automatic logic [COUNT_W-1:0] period_of(input logic [5:0] idx);
    logic [3:0] shamt;
    shamt = 4'd12 - idx[5:2];
    return (idx <= 6'd47) ? (COUNT_W'(1) << shamt) : COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fm_operator_envelope_generator_unit.sv
// Top level of the FM operator envelope generator: config bank, controller
// and datapath. Depends on fmeg_pkg, fmeg_cfg, fmeg_ctrl and fmeg_dp.
`timescale 1ns / 1ps
`default_nettype none

// Four-phase (attack, decay, sustain, release) amplitude envelope for one FM
// operator. Each input beat is a tick, a phase change or a restart, and gives
// exactly one result beat with the attenuation and phase after it. A set-phase
// or restart beat goes from idle straight to the done state; a tick passes
// through the scan state, where the datapath's overflow loop runs one step per
// clock (usually zero or one step per tick, at most 4096 after a phase change
// to a short period). The finished result sits in an output register, so the
// next beat is taken while it waits; a stalled output holds the block only when
// the following result is ready. The user must write configuration registers via
// cfg_wr_en / cfg_addr / cfg_wdata while the block is idle; it is not enforced.

module fm_operator_envelope_generator_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [7:0]                   in_tdata,   // [1:0] new_phase
  input  wire logic [1:0]                   in_tuser,   // [1:0] op
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [15:0]                       out_tdata,  // [9:0] attenuation, [11:10] phase
  input  wire logic                         cfg_wr_en,
  input  wire logic [fmeg_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [fmeg_pkg::CFG_DW-1:0]  cfg_wdata
);
  import fmeg_pkg::*;

  cfg_t               cfg;
  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [ATTEN_W-1:0] attenuation;
  logic [1:0]         phase;

  fmeg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fmeg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fmeg_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .in_op           (in_tuser),
    .in_new_phase    (in_tdata[1:0]),
    .sts             (sts),
    .out_attenuation (attenuation),
    .out_phase       (phase)
  );

  assign out_tdata = {4'b0000, phase, attenuation};

endmodule

`default_nettype wire

>>> hw/rtl/fmeg_cfg.sv
// Configuration register bank for the envelope generator.
// Depends on fmeg_pkg for the register codes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module fmeg_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [fmeg_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [fmeg_pkg::CFG_DW-1:0]   cfg_wdata,
  output fmeg_pkg::cfg_t                     cfg
);
  import fmeg_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ATTACK_RATE:   cfg_nxt.attack_rate   = cfg_wdata[3:0];
        REG_DECAY_RATE:    cfg_nxt.decay_rate    = cfg_wdata[3:0];
        REG_SUSTAIN_RATE:  cfg_nxt.sustain_rate  = cfg_wdata[3:0];
        REG_RELEASE_RATE:  cfg_nxt.release_rate  = cfg_wdata[3:0];
        REG_SUSTAIN_LEVEL: cfg_nxt.sustain_level = cfg_wdata[3:0];
        REG_KS_MODE:       cfg_nxt.ks_mode       = ks_mode_t'(cfg_wdata[1:0]);
        REG_KEY_CODE:      cfg_nxt.key_code      = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_rate   <= 4'd0;
      cfg_r.decay_rate    <= 4'd0;
      cfg_r.sustain_rate  <= 4'd0;
      cfg_r.release_rate  <= 4'd0;
      cfg_r.sustain_level <= 4'd15;
      cfg_r.ks_mode       <= KS_NONE;
      cfg_r.key_code      <= 5'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hw/rtl/fmeg_ctrl.sv
// Controller state machine: sequences one beat through apply, overflow scan (ticks
// only) and output capture. Depends on fmeg_pkg for states, opcodes and command types.
`timescale 1ns / 1ps
`default_nettype none

module fmeg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [1:0]    in_op,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  fmeg_pkg::dp_sts_t  sts,
  output fmeg_pkg::dp_cmd_t  cmd
);
  import fmeg_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (op_t'(in_op) == OP_TICK) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (!sts.ovf_pending) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid;
      end
      ST_SCAN: cmd.ovf_step = sts.ovf_pending;
      ST_DONE: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> hw/rtl/fmeg_dp.sv
// Envelope datapath: phase, attenuation, period, cycle counter, step index and
// the output register. Depends on fmeg_pkg for the rate helpers and increment table.
`timescale 1ns / 1ps
`default_nettype none

module fmeg_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  fmeg_pkg::cfg_t                    cfg,
  input  fmeg_pkg::dp_cmd_t                 cmd,
  input  wire logic [1:0]                   in_op,
  input  wire logic [1:0]                   in_new_phase,
  output fmeg_pkg::dp_sts_t                 sts,
  output logic [fmeg_pkg::ATTEN_W-1:0]      out_attenuation,
  output logic [1:0]                        out_phase
);
  import fmeg_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [ATTEN_W-1:0]   atten_r, atten_nxt;
  logic [COUNT_W-1:0]   period_r, period_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [2:0]           step_r, step_nxt;
  logic [ATTEN_W-1:0]   out_atten_r;
  phase_t               out_phase_r;

  logic [5:0]           idx_ph [4];
  logic [2:0]           step_inc;
  logic [3:0]           inc_att;
  logic [ATTEN_W:0]     atten_p1;
  logic [14:0]          prod;
  logic [14:0]          prod_rnd;
  logic [ATTEN_W:0]     dec;
  logic [ATTEN_W-1:0]   att_new;
  logic [ATTEN_W:0]     dec_sum;
  logic [ATTEN_W:0]     rel_sum;
  logic [ATTEN_W-1:0]   dec_sat;
  logic [ATTEN_W-1:0]   rel_sat;
  logic [ATTEN_W-1:0]   bound;

  always_comb begin
    idx_ph[PH_ATTACK]  = rate_index(cfg.attack_rate,  cfg.ks_mode, cfg.key_code);
    idx_ph[PH_DECAY]   = rate_index(cfg.decay_rate,   cfg.ks_mode, cfg.key_code);
    idx_ph[PH_SUSTAIN] = rate_index(cfg.sustain_rate, cfg.ks_mode, cfg.key_code);
    idx_ph[PH_RELEASE] = rate_index(cfg.release_rate, cfg.ks_mode, cfg.key_code);
  end

  assign step_inc = step_r + 3'd1;

  // Attack: subtract ceil((atten + 1) * inc / 8), doubled increment at the top rates.
  always_comb begin
    inc_att = {1'b0, inc_lookup(idx_ph[PH_ATTACK], step_inc)};
    if (idx_ph[PH_ATTACK] >= 6'd62) begin
      inc_att = inc_att << 1;
    end
    atten_p1 = {1'b0, atten_r} + 11'd1;
    prod     = {4'b0000, atten_p1} * {11'd0, inc_att};
    prod_rnd = prod + 15'd7;
    dec      = prod_rnd[13:3];
    if (idx_ph[PH_ATTACK] < 6'd4) begin
      att_new = atten_r;
    end else if (dec >= {1'b0, atten_r}) begin
      att_new = '0;
    end else begin
      att_new = atten_r - dec[ATTEN_W-1:0];
    end
  end

  always_comb begin
    dec_sum = {1'b0, atten_r} + 11'(inc_lookup(idx_ph[PH_DECAY], step_inc));
    rel_sum = {1'b0, atten_r} + 11'(inc_lookup(idx_ph[PH_RELEASE], step_inc));
    dec_sat = dec_sum[ATTEN_W] ? ATT_SAT : dec_sum[ATTEN_W-1:0];
    rel_sat = rel_sum[ATTEN_W] ? ATT_SAT : rel_sum[ATTEN_W-1:0];
    bound   = (cfg.sustain_level == 4'd15) ? ATT_MAX : {2'b00, cfg.sustain_level, 4'b0000};
  end

  always_comb begin
    phase_nxt  = phase_r;
    atten_nxt  = atten_r;
    period_nxt = period_r;
    count_nxt  = count_r;
    step_nxt   = step_r;
    if (cmd.start) begin
      case (op_t'(in_op))
        OP_TICK:      count_nxt = count_r + COUNT_W'(1);
        OP_SET_PHASE: begin
          phase_nxt  = phase_t'(in_new_phase);
          period_nxt = period_of(idx_ph[in_new_phase]);
        end
        OP_RESTART: begin
          atten_nxt = ATT_MAX;
          phase_nxt = PH_RELEASE;
        end
        default: phase_nxt = phase_r;
      endcase
    end else if (cmd.ovf_step) begin
      count_nxt = count_r - period_r;
      step_nxt  = step_inc;
      case (phase_r)
        PH_ATTACK: begin
          atten_nxt = att_new;
          if (att_new == '0) begin
            phase_nxt  = PH_DECAY;
            period_nxt = period_of(idx_ph[PH_DECAY]);
          end
        end
        PH_DECAY: begin
          atten_nxt = dec_sat;
          if (dec_sat >= bound) begin
            phase_nxt  = PH_SUSTAIN;
            period_nxt = period_of(idx_ph[PH_SUSTAIN]);
          end
        end
        PH_SUSTAIN: begin
          if (idx_ph[PH_SUSTAIN] >= 6'd4) begin
            atten_nxt = (rel_sat >= ATT_MAX) ? ATT_MAX : rel_sat;
          end else begin
            atten_nxt = (atten_r >= ATT_MAX) ? ATT_MAX : atten_r;
          end
        end
        default: atten_nxt = (rel_sat >= ATT_MAX) ? ATT_MAX : rel_sat;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_RELEASE;
      atten_r  <= ATT_MAX;
      period_r <= COUNT_W'(1);
      count_r  <= '0;
      step_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      atten_r  <= atten_nxt;
      period_r <= period_nxt;
      count_r  <= count_nxt;
      step_r   <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_atten_r <= atten_r;
      out_phase_r <= phase_r;
    end
  end

  assign sts.ovf_pending = (count_r >= period_r);
  assign out_attenuation = out_atten_r;
  assign out_phase       = out_phase_r;

endmodule

`default_nettype wire

>>> hw/rtl/fmeg_checker.sv
// Port-level checker for the envelope generator top level, bound in below.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module fmeg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  logic [1:0] pend_r, pend_nxt;
  logic       in_beat, out_beat;

  assign in_beat  = in_tvalid && in_tready;
  assign out_beat = out_tvalid && out_tready;

  // Track beats taken in but not yet delivered.
  always_comb begin
    pend_nxt = pend_r;
    if (in_beat && !out_beat) begin
      pend_nxt = (pend_r == 2'd3) ? pend_r : pend_r + 2'd1;
    end else if (out_beat && !in_beat) begin
      pend_nxt = (pend_r == 2'd0) ? pend_r : pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output data changed while stalled");

  a_no_invented_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> pend_r != 2'd0)
    else $error("result beat without an accepted input");

  a_bounded_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd2 |-> !in_tready)
    else $error("input taken with two results outstanding");

endmodule

bind fm_operator_envelope_generator_unit fmeg_checker u_fmeg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the FM operator envelope generator unit.
// Drives stream beats and config writes, predicts each result beat in place.
// Depends on fmeg_pkg and fm_operator_envelope_generator_unit.
`timescale 1ns / 1ps

module testbench;
  import fmeg_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;  // unused op code, reports state only
  localparam int RAND_PHASES = 6;
  localparam int RAND_BEATS  = 1200;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [9:0] att;
    phase_t     ph;
  } env_result_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  // sel is the op of a beat row or the register of a config row; val is the
  // new phase or the write data.
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  sel;
    logic [4:0]  val;
    logic        known;
    env_result_t exp;
  } row_t;

  localparam int N_DIR = 29;
  localparam row_t DIR_ROWS [N_DIR] = '{
    '{ROW_BEAT, OP_TICK,           PH_ATTACK,  1'b1, '{10'd511, PH_RELEASE}},
    '{ROW_BEAT, OP_NOP,            PH_RELEASE, 1'b1, '{10'd511, PH_RELEASE}},
    '{ROW_BEAT, OP_SET_PHASE,      PH_RELEASE, 1'b1, '{10'd511, PH_RELEASE}},
    '{ROW_BEAT, OP_TICK,           PH_ATTACK,  1'b1, '{10'd511, PH_RELEASE}},
    '{ROW_BEAT, OP_TICK,           PH_SUSTAIN, 1'b1, '{10'd511, PH_RELEASE}},
    '{ROW_CFG,  REG_RELEASE_RATE,  5'd15,      1'b0, '{10'd0,   PH_ATTACK}},
    // short period latched with a count already built up: several steps per tick
    '{ROW_BEAT, OP_SET_PHASE,      PH_RELEASE, 1'b1, '{10'd511, PH_RELEASE}},
    '{ROW_BEAT, OP_TICK,           PH_ATTACK,  1'b1, '{10'd511, PH_RELEASE}},
    '{ROW_CFG,  REG_KS_MODE,       KS_DIV8,    1'b0, '{10'd0,   PH_ATTACK}},
    '{ROW_CFG,  REG_KEY_CODE,      5'd31,      1'b0, '{10'd0,   PH_ATTACK}},
    '{ROW_CFG,  REG_ATTACK_RATE,   5'd15,      1'b0, '{10'd0,   PH_ATTACK}},
    '{ROW_BEAT, OP_SET_PHASE,      PH_ATTACK,  1'b1, '{10'd511, PH_ATTACK}},
    // attack index below 4 with the period still at 1: level must not move
    '{ROW_CFG,  REG_ATTACK_RATE,   5'd0,       1'b0, '{10'd0,   PH_ATTACK}},
    '{ROW_BEAT, OP_TICK,           PH_ATTACK,  1'b1, '{10'd511, PH_ATTACK}},
    // fast attack (index 63) takes the full level in one step
    '{ROW_CFG,  REG_ATTACK_RATE,   5'd15,      1'b0, '{10'd0,   PH_ATTACK}},
    '{ROW_BEAT, OP_TICK,           PH_ATTACK,  1'b1, '{10'd0,   PH_DECAY}},
    '{ROW_BEAT, OP_SET_PHASE,      PH_ATTACK,  1'b1, '{10'd0,   PH_ATTACK}},
    // zero level at low attack index still moves on to decay
    '{ROW_CFG,  REG_ATTACK_RATE,   5'd0,       1'b0, '{10'd0,   PH_ATTACK}},
    '{ROW_BEAT, OP_TICK,           PH_ATTACK,  1'b1, '{10'd0,   PH_DECAY}},
    '{ROW_CFG,  REG_SUSTAIN_LEVEL, 5'd0,       1'b0, '{10'd0,   PH_ATTACK}},
    '{ROW_CFG,  REG_DECAY_RATE,    5'd15,      1'b0, '{10'd0,   PH_ATTACK}},
    '{ROW_BEAT, OP_SET_PHASE,      PH_DECAY,   1'b1, '{10'd0,   PH_DECAY}},
    '{ROW_BEAT, OP_TICK,           PH_RELEASE, 1'b0, '{10'd0,   PH_ATTACK}},
    '{ROW_CFG,  REG_SUSTAIN_RATE,  5'd15,      1'b0, '{10'd0,   PH_ATTACK}},
    '{ROW_BEAT, OP_TICK,           PH_DECAY,   1'b0, '{10'd0,   PH_ATTACK}},
    '{ROW_BEAT, OP_RESTART,        PH_DECAY,   1'b1, '{10'd511, PH_RELEASE}},
    '{ROW_BEAT, OP_SET_PHASE,      PH_SUSTAIN, 1'b1, '{10'd511, PH_SUSTAIN}},
    '{ROW_BEAT, OP_TICK,           PH_ATTACK,  1'b0, '{10'd0,   PH_ATTACK}},
    '{ROW_BEAT, OP_NOP,            PH_ATTACK,  1'b0, '{10'd0,   PH_ATTACK}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [1:0] new_phase
  logic [1:0]  in_tuser = 2'd0;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [9:0] attenuation, [11:10] phase
  logic                cfg_wr_en = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  fm_operator_envelope_generator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  env_result_t expected_env[$];
  int fail_count = 0;
  int beats_sent = 0;
  bit no_idle = 1'b0;

  // Shadow of the config bank, at its reset values.
  logic [3:0] ar_sh = 4'd0, dr_sh = 4'd0, sr_sh = 4'd0, rr_sh = 4'd0;
  logic [3:0] sl_sh = 4'd15;
  ks_mode_t   ks_sh = KS_NONE;
  logic [4:0] kc_sh = 5'd0;

  // Envelope state as predicted.
  phase_t env_phase = PH_RELEASE;
  int env_atten = 511;
  int env_period = 1;
  int env_count = 0;
  int env_step = 0;

  function automatic int scaled_index(input logic [3:0] rate);
    int idx;
    idx = 4 * rate;
    case (ks_sh)
      KS_DIV8:  idx += kc_sh >> 3;
      KS_DIV2:  idx += kc_sh >> 1;
      KS_REMAP: idx += ((kc_sh & 5'h1C) >> 1) | (kc_sh & 5'h01);
      default:  ;
    endcase
    return (idx > 63) ? 63 : idx;
  endfunction

  // One nibble per step, step 0 in the low nibble.
  function automatic int step_increment(input int idx, input int step);
    logic [31:0] row_bits;
    int row;
    row = (idx < 52) ? (idx & 3) : (idx - 48);
    case (row)
      0:       row_bits = 32'h10101010;
      1:       row_bits = 32'h10111010;
      2:       row_bits = 32'h11101110;
      3:       row_bits = 32'h11111110;
      4:       row_bits = 32'h11111111;
      5:       row_bits = 32'h21112111;
      6:       row_bits = 32'h21212121;
      7:       row_bits = 32'h22212221;
      8:       row_bits = 32'h22222222;
      9:       row_bits = 32'h42224222;
      10:      row_bits = 32'h42424242;
      11:      row_bits = 32'h44424442;
      default: row_bits = 32'h44444444;
    endcase
    return row_bits[4*step +: 4];
  endfunction

  function automatic int sat_add(input int a, input int b);
    return (a + b > 1023) ? 1023 : a + b;
  endfunction

  function automatic int phase_rate_index(input phase_t ph);
    case (ph)
      PH_ATTACK:  return scaled_index(ar_sh);
      PH_DECAY:   return scaled_index(dr_sh);
      PH_SUSTAIN: return scaled_index(sr_sh);
      default:    return scaled_index(rr_sh);
    endcase
  endfunction

  task automatic latch_phase(input phase_t ph);
    int idx;
    env_phase = ph;
    idx = phase_rate_index(ph);
    env_period = (idx <= 47) ? (1 << (12 - idx / 4)) : 1;
  endtask

  task automatic run_overflow();
    int idx, inc, bound, dec;
    env_step = (env_step + 1) & 7;
    case (env_phase)
      PH_ATTACK: begin
        idx = scaled_index(ar_sh);
        inc = step_increment(idx, env_step);
        if (idx >= 62) inc = inc * 2;
        if (idx >= 4) begin
          dec = ((env_atten + 1) * inc + 7) >> 3;
          env_atten = (dec >= env_atten) ? 0 : env_atten - dec;
        end
        if (env_atten == 0) latch_phase(PH_DECAY);
      end
      PH_DECAY: begin
        env_atten = sat_add(env_atten, step_increment(scaled_index(dr_sh), env_step));
        bound = (sl_sh == 4'd15) ? 511 : sl_sh * 16;
        if (env_atten >= bound) latch_phase(PH_SUSTAIN);
      end
      PH_SUSTAIN: begin
        if (scaled_index(sr_sh) >= 4)
          env_atten = sat_add(env_atten, step_increment(scaled_index(rr_sh), env_step));
        if (env_atten >= 511) env_atten = 511;
      end
      default: begin
        env_atten = sat_add(env_atten, step_increment(scaled_index(rr_sh), env_step));
        if (env_atten >= 511) env_atten = 511;
      end
    endcase
  endtask

  task automatic advance_envelope(input logic [1:0] op, input logic [1:0] np);
    case (op)
      OP_TICK: begin
        env_count = (env_count + 1) & 13'h1FFF;
        while (env_count >= env_period) begin
          env_count -= env_period;
          run_overflow();
        end
      end
      OP_SET_PHASE: latch_phase(phase_t'(np));
      OP_RESTART: begin
        env_atten = 511;
        env_phase = PH_RELEASE;
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Leaves in_tvalid high after the accepted beat; the next call either
  // replaces the data in the same step or drops valid for a gap.
  task automatic push_beat(input logic [1:0] op, input logic [1:0] np,
                           input logic typed = 1'b0, input env_result_t typed_res = '0);
    int gap;
    env_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, np};
    do @(posedge clk); while (!in_tready);
    advance_envelope(op, np);
    res.att = env_atten[9:0];
    res.ph  = env_phase;
    expected_env.push_back(typed ? typed_res : res);
    beats_sent++;
  endtask

  task automatic wait_results_drained();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (expected_env.size() != 0) @(posedge clk);
  endtask

  task automatic write_env_reg(input cfg_reg_t r, input logic [4:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    @(posedge clk);
    case (r)
      REG_ATTACK_RATE:   ar_sh = v[3:0];
      REG_DECAY_RATE:    dr_sh = v[3:0];
      REG_SUSTAIN_RATE:  sr_sh = v[3:0];
      REG_RELEASE_RATE:  rr_sh = v[3:0];
      REG_SUSTAIN_LEVEL: sl_sh = v[3:0];
      REG_KS_MODE:       ks_sh = ks_mode_t'(v[1:0]);
      REG_KEY_CODE:      kc_sh = v;
      default:           ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    env_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_env.size() == 0) begin
        $display("%0t: unexpected result beat att %0d phase %0d",
                 $time, out_tdata[9:0], out_tdata[11:10]);
        fail_count++;
      end else begin
        want = expected_env.pop_front();
        if (out_tdata[9:0] !== want.att) begin
          $display("%0t: attenuation expected %0d got %0d", $time, want.att, out_tdata[9:0]);
          fail_count++;
        end
        if (out_tdata[11:10] !== want.ph) begin
          $display("%0t: phase expected %0d got %0d", $time, want.ph, out_tdata[11:10]);
          fail_count++;
        end
      end
    end
  end

  // Result side backpressure.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (no_idle) begin
        out_tready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        hold = pick_gap();
        out_tready <= (hold == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("testbench failed");
    $finish;
  end

  initial begin
    int i, p, k, phase_start;
    logic [3:0] v_ar, v_dr, v_sr, v_rr, v_sl;
    logic [1:0] v_ks;
    logic [4:0] v_kc;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        wait_results_drained();
        write_env_reg(cfg_reg_t'(DIR_ROWS[i].sel), DIR_ROWS[i].val);
      end else begin
        push_beat(DIR_ROWS[i].sel[1:0], DIR_ROWS[i].val[1:0],
                  DIR_ROWS[i].known, DIR_ROWS[i].exp);
      end
    end

    for (p = 0; p < RAND_PHASES; p++) begin
      wait_results_drained();
      case (p)
        0: begin
          v_ar = 4'd15; v_dr = 4'd15; v_sr = 4'd15; v_rr = 4'd15;
          v_sl = 4'd15; v_ks = KS_DIV2; v_kc = 5'd31;
        end
        1: begin
          v_ar = 4'd0; v_dr = 4'd0; v_sr = 4'd0; v_rr = 4'd0;
          v_sl = 4'd0; v_ks = KS_REMAP; v_kc = 5'd0;
        end
        default: begin
          // mostly fast rates, so phases turn over within a few dozen ticks
          v_ar = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(8, 15);
          v_dr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(8, 15);
          v_sr = ($urandom_range(0, 2) == 0) ? 4'd0 : $urandom_range(8, 15);
          v_rr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(8, 15);
          v_sl = $urandom_range(0, 15);
          v_ks = $urandom_range(0, 3);
          v_kc = $urandom_range(0, 31);
        end
      endcase
      write_env_reg(REG_ATTACK_RATE, v_ar);
      write_env_reg(REG_DECAY_RATE, v_dr);
      write_env_reg(REG_SUSTAIN_RATE, v_sr);
      write_env_reg(REG_RELEASE_RATE, v_rr);
      write_env_reg(REG_SUSTAIN_LEVEL, v_sl);
      write_env_reg(REG_KS_MODE, v_ks);
      write_env_reg(REG_KEY_CODE, v_kc);

      phase_start = beats_sent;
      while (beats_sent - phase_start < RAND_BEATS / RAND_PHASES) begin
        no_idle = (p == 3) || ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 99) < 75) begin
          // key on, hold, key off, let it ring out
          if ($urandom_range(0, 4) == 0) push_beat(OP_RESTART, $urandom_range(0, 3));
          push_beat(OP_SET_PHASE, PH_ATTACK);
          k = $urandom_range(4, 60);
          repeat (k) push_beat(OP_TICK, $urandom_range(0, 3));
          if ($urandom_range(0, 3) == 0) push_beat(OP_SET_PHASE, $urandom_range(0, 3));
          push_beat(OP_SET_PHASE, PH_RELEASE);
          k = $urandom_range(2, 40);
          repeat (k) push_beat(OP_TICK, $urandom_range(0, 3));
        end else begin
          k = $urandom_range(1, 4);
          repeat (k) push_beat($urandom_range(0, 3), $urandom_range(0, 3));
        end
        if ($urandom_range(0, 29) == 0) wait_results_drained();
      end
    end

    no_idle = 1'b0;
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/fmeg_pkg.sv
hw/rtl/fmeg_cfg.sv
hw/rtl/fmeg_ctrl.sv
hw/rtl/fmeg_dp.sv
hw/rtl/fm_operator_envelope_generator_unit.sv
hw/rtl/fmeg_checker.sv
bench/testbench.sv
